// File: hdl/vnorm_pkg.sv
// Shared types and constants for the vector normalizer.
package vnorm_pkg;
   localparam int CB = 16;
   localparam int SUM_BITS = 2 * CB + 2;
   localparam int ROOT_BITS = CB + 1;
   localparam int FRAC = CB - 2;
   localparam int NUM_BITS = CB - 1 + FRAC;

   typedef struct packed {
      logic signed [CB-1:0] vec_x;
      logic signed [CB-1:0] vec_y;
      logic signed [CB-1:0] vec_z;
   } req_type;

   typedef struct packed {
      logic signed [CB-1:0] unit_x;
      logic signed [CB-1:0] unit_y;
      logic signed [CB-1:0] unit_z;
      logic [CB-1:0]        vec_length;
      logic                 zero_length;
   } rsp_type;
endpackage

// File: hdl/vnorm_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module vnorm_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [vnorm_pkg::SUM_BITS-1:0]  in_sum,
   input  logic [3*vnorm_pkg::CB-1:0]      in_tag,
   output logic                            out_valid,
   output logic [vnorm_pkg::ROOT_BITS-1:0] out_root,
   output logic [3*vnorm_pkg::CB-1:0]      out_tag
);
   localparam int N = vnorm_pkg::ROOT_BITS;
   localparam int SB = vnorm_pkg::SUM_BITS;
   localparam int RB = SB + 2;

   logic [N:0]         valid_ff;
   logic [RB-1:0]      rem_ff  [N+1];
   logic [N-1:0]       root_ff [N+1];
   logic [SB-1:0]      num_ff  [N+1];
   logic [3*vnorm_pkg::CB-1:0] tag_ff [N+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[N-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      num_ff[0]  <= in_sum;
      tag_ff[0]  <= in_tag;
   end

   for (genvar s = 0; s < N; s++) begin : g_stage
      logic [RB-1:0] rem_in;
      logic [RB-1:0] trial;
      assign rem_in = {rem_ff[s][RB-3:0], num_ff[s][SB-1 -: 2]};
      assign trial  = {{(RB-N-2){1'b0}}, root_ff[s], 2'b01};
      always_ff @(posedge clock) begin
         num_ff[s+1] <= {num_ff[s][SB-3:0], 2'b00};
         tag_ff[s+1] <= tag_ff[s];
         if (rem_in >= trial) begin
            rem_ff[s+1]  <= rem_in - trial;
            root_ff[s+1] <= {root_ff[s][N-2:0], 1'b1};
         end else begin
            rem_ff[s+1]  <= rem_in;
            root_ff[s+1] <= {root_ff[s][N-2:0], 1'b0};
         end
      end
   end

   assign out_valid = valid_ff[N];
   assign out_root  = root_ff[N];
   assign out_tag   = tag_ff[N];
endmodule

// File: hdl/vnorm_div.sv
// One division lane: signed component over length, restoring, one bit per stage.
module vnorm_div (
   input  logic                            clock,
   input  logic signed [vnorm_pkg::CB-1:0] in_comp,
   input  logic [vnorm_pkg::ROOT_BITS-1:0] in_len,
   output logic signed [vnorm_pkg::CB-1:0] out_unit
);
   localparam int CB = vnorm_pkg::CB;
   localparam int NB = vnorm_pkg::NUM_BITS + 1;
   localparam int LB = vnorm_pkg::ROOT_BITS;

   logic [NB-1:0] num_ff [NB+1];
   logic [LB:0]   rem_ff [NB+1];
   logic [LB-1:0] den_ff [NB+1];
   logic          neg_ff [NB+1];
   logic [CB-1:0] mag;

   assign mag = in_comp[CB-1] ? CB'(-in_comp) : CB'(in_comp);

   always_ff @(posedge clock) begin
      num_ff[0] <= NB'({mag, {vnorm_pkg::FRAC{1'b0}}});
      rem_ff[0] <= '0;
      den_ff[0] <= in_len;
      neg_ff[0] <= in_comp[CB-1];
   end

   for (genvar s = 0; s < NB; s++) begin : g_stage
      logic [LB:0] shifted;
      assign shifted = {rem_ff[s][LB-1:0], num_ff[s][NB-1]};
      always_ff @(posedge clock) begin
         den_ff[s+1] <= den_ff[s];
         neg_ff[s+1] <= neg_ff[s];
         if (shifted >= {1'b0, den_ff[s]}) begin
            rem_ff[s+1] <= shifted - {1'b0, den_ff[s]};
            num_ff[s+1] <= {num_ff[s][NB-2:0], 1'b1};
         end else begin
            rem_ff[s+1] <= shifted;
            num_ff[s+1] <= {num_ff[s][NB-2:0], 1'b0};
         end
      end
   end

   assign out_unit = neg_ff[NB] ? -CB'(num_ff[NB]) : CB'(num_ff[NB]);
endmodule

// File: hdl/vector3_normalize_top.sv
// Top level of the 3D vector normalizer.
// Usage: drive req_data and pulse start; busy is held low, so one item may
// be taken every cycle. Each item yields one result on rsp_data, marked by
// rsp_strobe for a single cycle; the receiver cannot stall and must take it.
// Pipeline: the accepting edge registers the squares, a registered adder sums
// them, a 17-stage square root (one result bit per stage, after an input
// register) gives the length, then three divider lanes run side by side,
// 30 stages each after an input register (one quotient bit per stage), and
// a merging register packs the result.
// Throughput is one item per cycle, set by the fully pipelined root and
// divider lanes.
// A zero vector gives zero units, zero length and zero_length set.
// Reset clears the valid pipeline only; no results appear for items in
// flight at reset. There are no configuration registers.
module vector3_normalize_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  vnorm_pkg::req_type   req_data,
   output logic                 rsp_strobe,
   output vnorm_pkg::rsp_type   rsp_data
);
   localparam int CB = vnorm_pkg::CB;
   localparam int SB = vnorm_pkg::SUM_BITS;
   localparam int LB = vnorm_pkg::ROOT_BITS;
   localparam int DLAT = vnorm_pkg::NUM_BITS + 2;

   logic [2*CB-1:0]   sq_x_ff, sq_y_ff, sq_z_ff;
   logic [3*CB-1:0]   tag_ff;
   logic              v0_ff;
   logic [SB-1:0]     sum_ff;
   logic [3*CB-1:0]   tag1_ff;
   logic              v1_ff;
   logic              rt_valid;
   logic [LB-1:0]     root;
   logic [3*CB-1:0]   rt_tag;
   logic [DLAT-1:0]   dv_ff;
   logic [LB-1:0]     len_ff [DLAT];
   logic signed [CB-1:0] ux, uy, uz;
   vnorm_pkg::rsp_type rsp_ff;
   logic              strobe_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      sq_x_ff <= (2*CB)'(req_data.vec_x) * (2*CB)'(req_data.vec_x);
      sq_y_ff <= (2*CB)'(req_data.vec_y) * (2*CB)'(req_data.vec_y);
      sq_z_ff <= (2*CB)'(req_data.vec_z) * (2*CB)'(req_data.vec_z);
      tag_ff  <= req_data;
      sum_ff  <= SB'(sq_x_ff) + SB'(sq_y_ff) + SB'(sq_z_ff);
      tag1_ff <= tag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff     <= 1'b0;
         v1_ff     <= 1'b0;
         dv_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         v0_ff     <= start;
         v1_ff     <= v0_ff;
         dv_ff     <= {dv_ff[DLAT-2:0], rt_valid};
         strobe_ff <= dv_ff[DLAT-1];
      end
   end

   vnorm_sqrt u_sqrt (
      .clock(clock), .reset(reset), .in_valid(v1_ff), .in_sum(sum_ff),
      .in_tag(tag1_ff), .out_valid(rt_valid), .out_root(root), .out_tag(rt_tag)
   );

   vnorm_div u_div_x (.clock(clock), .in_comp(rt_tag[3*CB-1:2*CB]), .in_len(root),
                      .out_unit(ux));
   vnorm_div u_div_y (.clock(clock), .in_comp(rt_tag[2*CB-1:CB]), .in_len(root),
                      .out_unit(uy));
   vnorm_div u_div_z (.clock(clock), .in_comp(rt_tag[CB-1:0]), .in_len(root),
                      .out_unit(uz));

   always_ff @(posedge clock) begin
      len_ff[0] <= root;
      for (int i = 1; i < DLAT; i++) begin
         len_ff[i] <= len_ff[i-1];
      end
   end

   // merge lanes; a zero length forces zero units
   always_ff @(posedge clock) begin
      if (len_ff[DLAT-1] == '0) begin
         rsp_ff.unit_x      <= '0;
         rsp_ff.unit_y      <= '0;
         rsp_ff.unit_z      <= '0;
         rsp_ff.zero_length <= 1'b1;
      end else begin
         rsp_ff.unit_x      <= ux;
         rsp_ff.unit_y      <= uy;
         rsp_ff.unit_z      <= uz;
         rsp_ff.zero_length <= 1'b0;
      end
      rsp_ff.vec_length <= CB'(len_ff[DLAT-1]);
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;
endmodule
